@@ design/fbpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpf_pkg
// Shared types and constants of the footprint box predicate filter.
// ----------------------------------------------------------------------------
package fbpf_pkg;

  localparam int unsigned MAX_BATCH_DEF = 32'd65536;

  localparam int COORD_W = 32;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;
  localparam int POS_OUT_W   = 16;
  localparam int MATCH_OUT_W = 17;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [2:0] {
    REG_BOX_X_MIN    = 3'd0,
    REG_BOX_X_MAX    = 3'd1,
    REG_BOX_Y_MIN    = 3'd2,
    REG_BOX_Y_MAX    = 3'd3,
    REG_PREDICATE    = 3'd4,
    REG_INVERT       = 3'd5,
    REG_POINT_MODE   = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_OVERLAPS  = 4'd0,
    OP_CONTAINS  = 4'd1,
    OP_WITHIN    = 4'd2,
    OP_SAME      = 4'd3,
    OP_OVERLEFT  = 4'd4,
    OP_OVERRIGHT = 4'd5,
    OP_OVERABOVE = 4'd6,
    OP_OVERBELOW = 4'd7,
    OP_LEFT      = 4'd8,
    OP_RIGHT     = 4'd9,
    OP_ABOVE     = 4'd10,
    OP_BELOW     = 4'd11,
    OP_COMMLEFT  = 4'd12,
    OP_COMMRIGHT = 4'd13,
    OP_COMMABOVE = 4'd14,
    OP_COMMBELOW = 4'd15
  } op_t;

  // Footprint extent of one axis against the query bounds of that axis.
  typedef struct packed {
    logic min_gt_hi;
    logic max_lt_lo;
    logic min_le_lo;
    logic min_ge_lo;
    logic max_ge_hi;
    logic max_le_hi;
    logic min_eq_lo;
    logic max_eq_hi;
  } axis_flags_t;

endpackage

@@ design/fbpf_axis_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpf_axis_lane
// One axis lane: min/max over the four corners (corner_0 alone in point
// mode), registered, then compared against the query bounds of that axis.
// ----------------------------------------------------------------------------
module fbpf_axis_lane (
  input  logic                clk,
  input  logic                load,
  input  logic                point_mode,
  input  fbpf_pkg::coord_t    corner_0,
  input  fbpf_pkg::coord_t    corner_1,
  input  fbpf_pkg::coord_t    corner_2,
  input  fbpf_pkg::coord_t    corner_3,
  input  fbpf_pkg::coord_t    bound_lo,
  input  fbpf_pkg::coord_t    bound_hi,
  output fbpf_pkg::axis_flags_t flags
);
  import fbpf_pkg::*;

  coord_t min_a, min_b, max_a, max_b;
  coord_t ext_min_next, ext_max_next;
  coord_t ext_min, ext_max;

  always_comb begin
    min_a = (corner_0 < corner_1) ? corner_0 : corner_1;
    min_b = (corner_2 < corner_3) ? corner_2 : corner_3;
    max_a = (corner_0 < corner_1) ? corner_1 : corner_0;
    max_b = (corner_2 < corner_3) ? corner_3 : corner_2;
    if (point_mode) begin
      ext_min_next = corner_0;
      ext_max_next = corner_0;
    end else begin
      ext_min_next = (min_a < min_b) ? min_a : min_b;
      ext_max_next = (max_a < max_b) ? max_b : max_a;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ext_min <= ext_min_next;
      ext_max <= ext_max_next;
    end
  end

  always_comb begin
    flags.min_gt_hi = ext_min >  bound_hi;
    flags.max_lt_lo = ext_max <  bound_lo;
    flags.min_le_lo = ext_min <= bound_lo;
    flags.min_ge_lo = ext_min >= bound_lo;
    flags.max_ge_hi = ext_max >= bound_hi;
    flags.max_le_hi = ext_max <= bound_hi;
    flags.min_eq_lo = ext_min == bound_lo;
    flags.max_eq_hi = ext_max == bound_hi;
  end

endmodule

@@ design/fbpf_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpf_merge
// Combine latitude and longitude lane flags into the selected predicate.
// ----------------------------------------------------------------------------
module fbpf_merge (
  input  fbpf_pkg::op_t         op,
  input  logic                  invert,
  input  fbpf_pkg::axis_flags_t lat,
  input  fbpf_pkg::axis_flags_t lon,
  output logic                  pass
);
  import fbpf_pkg::*;

  logic hit;

  always_comb begin
    case (op)
      OP_OVERLAPS:  hit = !(lat.min_gt_hi || lat.max_lt_lo ||
                            lon.min_gt_hi || lon.max_lt_lo);
      OP_CONTAINS:  hit = lat.min_le_lo && lat.max_ge_hi &&
                          lon.min_le_lo && lon.max_ge_hi;
      OP_WITHIN:    hit = lat.min_ge_lo && lat.max_le_hi &&
                          lon.min_ge_lo && lon.max_le_hi;
      OP_SAME:      hit = lat.min_eq_lo && lat.max_eq_hi &&
                          lon.min_eq_lo && lon.max_eq_hi;
      OP_OVERLEFT:  hit = lat.max_le_hi;
      OP_OVERRIGHT: hit = lat.min_ge_lo;
      OP_OVERABOVE: hit = lon.min_ge_lo;
      OP_OVERBELOW: hit = lon.max_le_hi;
      OP_LEFT:      hit = lat.max_lt_lo;
      OP_RIGHT:     hit = lat.min_gt_hi;
      OP_ABOVE:     hit = lon.min_gt_hi;
      OP_BELOW:     hit = lon.max_lt_lo;
      OP_COMMLEFT:  hit = lat.max_ge_hi;
      OP_COMMRIGHT: hit = lat.min_le_lo;
      OP_COMMABOVE: hit = lon.min_le_lo;
      OP_COMMBELOW: hit = lon.max_ge_hi;
      default:      hit = 1'b0;
    endcase
    pass = hit ^ invert;
  end

endmodule

@@ design/footprint_box_predicate_filter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// footprint_box_predicate_filter_core
// Bounding-box predicate filter over four-corner footprints, with batch
// position and compaction slot counting.
// Path: input beat, lane min/max register stage, merge/count output register.
// Throughput: one beat per cycle while out_stall is low; set by both
// register stages.
// Reset: clears config registers, pipeline valids, position and match counts.
// ----------------------------------------------------------------------------
module footprint_box_predicate_filter_core #(
  parameter int unsigned MAX_BATCH = fbpf_pkg::MAX_BATCH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // config port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fbpf_pkg::CFG_AW-1:0]      paddr,
  input  logic [fbpf_pkg::CFG_DW-1:0]      pwdata,
  output logic [fbpf_pkg::CFG_DW-1:0]      prdata,
  output logic                             pready,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  fbpf_pkg::coord_t                 lat_corner_0,
  input  fbpf_pkg::coord_t                 lat_corner_1,
  input  fbpf_pkg::coord_t                 lat_corner_2,
  input  fbpf_pkg::coord_t                 lat_corner_3,
  input  fbpf_pkg::coord_t                 lon_corner_0,
  input  fbpf_pkg::coord_t                 lon_corner_1,
  input  fbpf_pkg::coord_t                 lon_corner_2,
  input  fbpf_pkg::coord_t                 lon_corner_3,
  input  logic                             batch_end,
  // output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             passed,
  output logic [fbpf_pkg::POS_OUT_W-1:0]   item_position,
  output logic [fbpf_pkg::POS_OUT_W-1:0]   write_slot,
  output logic [fbpf_pkg::MATCH_OUT_W-1:0] matches_so_far,
  output logic                             batch_done
);
  import fbpf_pkg::*;

  localparam int POS_W = $clog2(MAX_BATCH);
  localparam int CNT_W = $clog2(MAX_BATCH + 1);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(MAX_BATCH - 1);
  localparam logic [CNT_W-1:0] MATCH_CAP = CNT_W'(MAX_BATCH);

  // config registers
  coord_t   box_x_min, box_x_max, box_y_min, box_y_max;
  op_t      predicate_select;
  logic     invert_result;
  logic     point_mode;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x_min        <= '0;
      box_x_max        <= '0;
      box_y_min        <= '0;
      box_y_max        <= '0;
      predicate_select <= OP_OVERLAPS;
      invert_result    <= 1'b0;
      point_mode       <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BOX_X_MIN:  box_x_min        <= coord_t'(pwdata);
        REG_BOX_X_MAX:  box_x_max        <= coord_t'(pwdata);
        REG_BOX_Y_MIN:  box_y_min        <= coord_t'(pwdata);
        REG_BOX_Y_MAX:  box_y_max        <= coord_t'(pwdata);
        REG_PREDICATE:  predicate_select <= op_t'(pwdata[3:0]);
        REG_INVERT:     invert_result    <= pwdata[0];
        REG_POINT_MODE: point_mode       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BOX_X_MIN:  prdata = CFG_DW'(box_x_min);
      REG_BOX_X_MAX:  prdata = CFG_DW'(box_x_max);
      REG_BOX_Y_MIN:  prdata = CFG_DW'(box_y_min);
      REG_BOX_Y_MAX:  prdata = CFG_DW'(box_y_max);
      REG_PREDICATE:  prdata = CFG_DW'(predicate_select);
      REG_INVERT:     prdata = CFG_DW'(invert_result);
      REG_POINT_MODE: prdata = CFG_DW'(point_mode);
      default:        prdata = '0;
    endcase
  end

  // pipeline control
  logic s1_valid;
  logic s1_batch_end;
  logic out_ready, s1_ready, load, advance;

  assign out_ready = !out_valid || !out_stall;
  assign s1_ready  = !s1_valid || out_ready;
  assign in_stall  = !s1_ready;
  assign load      = in_valid && s1_ready;
  assign advance   = s1_valid && out_ready;

  // lanes
  axis_flags_t lat_flags, lon_flags;

  fbpf_axis_lane u_lat_lane (
    .clk        (clk),
    .load       (load),
    .point_mode (point_mode),
    .corner_0   (lat_corner_0),
    .corner_1   (lat_corner_1),
    .corner_2   (lat_corner_2),
    .corner_3   (lat_corner_3),
    .bound_lo   (box_y_min),
    .bound_hi   (box_y_max),
    .flags      (lat_flags)
  );

  fbpf_axis_lane u_lon_lane (
    .clk        (clk),
    .load       (load),
    .point_mode (point_mode),
    .corner_0   (lon_corner_0),
    .corner_1   (lon_corner_1),
    .corner_2   (lon_corner_2),
    .corner_3   (lon_corner_3),
    .bound_lo   (box_x_min),
    .bound_hi   (box_x_max),
    .flags      (lon_flags)
  );

  logic pass;

  fbpf_merge u_merge (
    .op     (predicate_select),
    .invert (invert_result),
    .lat    (lat_flags),
    .lon    (lon_flags),
    .pass   (pass)
  );

  // batch counters
  logic [POS_W-1:0] position_counter, position_counter_next;
  logic [CNT_W-1:0] match_counter, match_bumped;

  always_comb begin
    match_bumped = match_counter;
    if (pass && (match_counter < MATCH_CAP)) begin
      match_bumped = match_counter + CNT_W'(1);
    end
    position_counter_next = (position_counter == POS_LAST) ? '0
                          : position_counter + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      position_counter <= '0;
      match_counter    <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (out_ready) begin
        out_valid <= s1_valid;
      end
      if (advance) begin
        if (s1_batch_end) begin
          position_counter <= '0;
          match_counter    <= '0;
        end else begin
          position_counter <= position_counter_next;
          match_counter    <= match_bumped;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_batch_end <= batch_end;
    end
    if (advance) begin
      passed         <= pass;
      item_position  <= POS_OUT_W'(position_counter);
      write_slot     <= POS_OUT_W'(match_counter);
      matches_so_far <= MATCH_OUT_W'(match_bumped);
      batch_done     <= s1_batch_end;
    end
  end

endmodule

@@ design/fbpf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpf_checker
// Port-level checks of the footprint box predicate filter output stream.
// ----------------------------------------------------------------------------
module fbpf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             passed,
  input logic [fbpf_pkg::POS_OUT_W-1:0]   item_position,
  input logic [fbpf_pkg::POS_OUT_W-1:0]   write_slot,
  input logic [fbpf_pkg::MATCH_OUT_W-1:0] matches_so_far,
  input logic                             batch_done
);
  import fbpf_pkg::*;

  logic batch_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_start <= 1'b1;
    end else if (out_valid && !out_stall) begin
      batch_start <= batch_done;
    end
  end

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(item_position) && $stable(write_slot)
      && $stable(matches_so_far) && $stable(passed) && $stable(batch_done))
    else $error("stalled output beat changed");

  a_batch_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && batch_start |-> item_position == '0 && write_slot == '0)
    else $error("batch did not restart at zero");

  a_slot_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!passed && matches_so_far[POS_OUT_W-1:0] == write_slot)
      || (passed && (matches_so_far[POS_OUT_W-1:0] == write_slot + POS_OUT_W'(1)
      || matches_so_far[POS_OUT_W-1:0] == write_slot)))
    else $error("match count disagrees with write slot");

endmodule

bind footprint_box_predicate_filter_core fbpf_checker u_fbpf_checker (.*);
